// ----- design/tcw_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_SETCUR = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;
   localparam logic [1:0] CMD_CLEAR = 2'd3;

   localparam logic [7:0] CH_BS = 8'd8;
   localparam logic [7:0] CH_TAB = 8'd9;
   localparam logic [7:0] CH_LF = 8'd10;
   localparam logic [7:0] CH_CR = 8'd13;
   localparam logic [7:0] CH_BLANK = 8'd32;

   localparam logic [1:0] REG_CHAR_ATTR = 2'd0;
   localparam logic [1:0] REG_FILL_ATTR = 2'd1;
   localparam logic [1:0] REG_TAB_WIDTH = 2'd2;

   localparam logic [7:0] CHAR_ATTR_RESET = 8'd7;
   localparam logic [7:0] FILL_ATTR_RESET = 8'd7;
   localparam logic [3:0] TAB_WIDTH_RESET = 4'd4;

   typedef logic [3:0] op_type;

   localparam op_type OP_NONE = 4'd0;
   localparam op_type OP_LATCH = 4'd1;
   localparam op_type OP_SETCUR = 4'd2;
   localparam op_type OP_RDCELL = 4'd3;
   localparam op_type OP_SWEEP_CLR = 4'd4;
   localparam op_type OP_CLEAR_START = 4'd5;
   localparam op_type OP_COPY = 4'd6;
   localparam op_type OP_FILL = 4'd7;
   localparam op_type OP_LASTROW = 4'd8;
   localparam op_type OP_NEWLINE = 4'd9;
   localparam op_type OP_PUT = 4'd10;
   localparam op_type OP_BS_DEC = 4'd11;
   localparam op_type OP_BS_RD = 4'd12;
   localparam op_type OP_BS_WR = 4'd13;
   localparam op_type OP_TAB_LOAD = 4'd14;
   localparam op_type OP_RSP = 4'd15;

   typedef struct packed {
      op_type op;
      logic   put_blank;
      logic   fill_init;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] char_code;
      logic       at_end;
      logic       last_row;
      logic       cur_zero;
      logic       copy_last;
      logic       fill_last;
      logic       tab_zero;
      logic       rsp_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- design/tcw_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_tvalid,
   output logic                        req_tready,
   output tcw_pkg::dp_cmd_type         dp_cmd,
   input  wire tcw_pkg::dp_status_type dp_status
);
   import tcw_pkg::*;

   localparam logic [3:0] S_INIT = 4'd0;
   localparam logic [3:0] S_INITFILL = 4'd1;
   localparam logic [3:0] S_IDLE = 4'd2;
   localparam logic [3:0] S_CMD = 4'd3;
   localparam logic [3:0] S_CLRFILL = 4'd4;
   localparam logic [3:0] S_CHAR = 4'd5;
   localparam logic [3:0] S_BSRD = 4'd6;
   localparam logic [3:0] S_BSWR = 4'd7;
   localparam logic [3:0] S_TAB = 4'd8;
   localparam logic [3:0] S_COPY = 4'd9;
   localparam logic [3:0] S_SFILL = 4'd10;
   localparam logic [3:0] S_SEND = 4'd11;
   localparam logic [3:0] S_DONE = 4'd12;

   logic [3:0] state_ff, state_in;
   logic [3:0] ret_ff, ret_in;

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      dp_cmd = '0;
      case (state_ff)
         S_INIT: begin
            dp_cmd.op = OP_SWEEP_CLR;
            state_in = S_INITFILL;
         end
         S_INITFILL: begin
            dp_cmd.op = OP_FILL;
            dp_cmd.fill_init = 1'b1;
            if (dp_status.fill_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               dp_cmd.op = OP_LATCH;
               state_in = S_CMD;
            end
         end
         S_CMD: begin
            case (dp_status.command)
               CMD_WRITE: begin
                  if (dp_status.at_end) begin
                     dp_cmd.op = OP_SWEEP_CLR;
                     ret_in = S_CHAR;
                     state_in = S_COPY;
                  end else begin
                     state_in = S_CHAR;
                  end
               end
               CMD_SETCUR: begin
                  dp_cmd.op = OP_SETCUR;
                  state_in = S_DONE;
               end
               CMD_READ: begin
                  dp_cmd.op = OP_RDCELL;
                  state_in = S_DONE;
               end
               default: begin
                  dp_cmd.op = OP_CLEAR_START;
                  state_in = S_CLRFILL;
               end
            endcase
         end
         S_CLRFILL: begin
            dp_cmd.op = OP_FILL;
            if (dp_status.fill_last) begin
               state_in = S_DONE;
            end
         end
         S_CHAR: begin
            case (dp_status.char_code)
               CH_LF: begin
                  state_in = S_DONE;
               end
               CH_CR: begin
                  if (dp_status.last_row) begin
                     dp_cmd.op = OP_SWEEP_CLR;
                     ret_in = S_DONE;
                     state_in = S_COPY;
                  end else begin
                     dp_cmd.op = OP_NEWLINE;
                     state_in = S_DONE;
                  end
               end
               CH_BS: begin
                  if (dp_status.cur_zero) begin
                     state_in = S_DONE;
                  end else begin
                     dp_cmd.op = OP_BS_DEC;
                     state_in = S_BSRD;
                  end
               end
               CH_TAB: begin
                  dp_cmd.op = OP_TAB_LOAD;
                  state_in = S_TAB;
               end
               default: begin
                  dp_cmd.op = OP_PUT;
                  state_in = S_DONE;
               end
            endcase
         end
         S_BSRD: begin
            dp_cmd.op = OP_BS_RD;
            state_in = S_BSWR;
         end
         S_BSWR: begin
            dp_cmd.op = OP_BS_WR;
            state_in = S_DONE;
         end
         S_TAB: begin
            if (dp_status.tab_zero) begin
               state_in = S_DONE;
            end else if (dp_status.at_end) begin
               dp_cmd.op = OP_SWEEP_CLR;
               ret_in = S_TAB;
               state_in = S_COPY;
            end else begin
               dp_cmd.op = OP_PUT;
               dp_cmd.put_blank = 1'b1;
            end
         end
         S_COPY: begin
            dp_cmd.op = OP_COPY;
            if (dp_status.copy_last) begin
               state_in = S_SFILL;
            end
         end
         S_SFILL: begin
            dp_cmd.op = OP_FILL;
            if (dp_status.fill_last) begin
               state_in = S_SEND;
            end
         end
         S_SEND: begin
            dp_cmd.op = OP_LASTROW;
            state_in = ret_ff;
         end
         S_DONE: begin
            if (dp_status.rsp_free) begin
               dp_cmd.op = OP_RSP;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         ret_ff <= S_DONE;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/tcw_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tcw_datapath #(
   parameter int COLUMNS = 80,
   parameter int ROWS = 25
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire [23:0]              req_tdata,
   output logic                    rsp_tvalid,
   input  wire                     rsp_tready,
   output logic [31:0]             rsp_tdata,
   input  wire                     csr_valid,
   output logic                    csr_ready,
   input  wire [1:0]               csr_index,
   input  wire [7:0]               csr_data,
   input  wire tcw_pkg::dp_cmd_type dp_cmd,
   output tcw_pkg::dp_status_type  dp_status
);
   import tcw_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam int IW = $clog2(CELLS);
   localparam int CW = $clog2(CELLS + 1);
   localparam int RW = $clog2(ROWS + 1);
   localparam int CLW = $clog2(COLUMNS);

   logic [15:0]    cells_mem [CELLS];

   logic [1:0]     cmd_ff;
   logic [7:0]     ch_ff;
   logic [6:0]     col_ff;
   logic [4:0]     row_ff;
   logic [CW-1:0]  lin_ff, lin_in;
   logic [RW-1:0]  crow_ff, crow_in;
   logic [CLW-1:0] ccol_ff, ccol_in;
   logic [IW-1:0]  sweep_ff, sweep_in;
   logic [3:0]     tab_ff, tab_in;
   logic [7:0]     char_attr_ff, fill_attr_ff;
   logic [3:0]     tab_width_ff;
   logic [15:0]    rdata_ff;
   logic           rsp_valid_ff;
   logic [31:0]    rsp_data_ff;

   logic [8:0]     colx;
   logic [7:0]     rowx;
   logic [CLW-1:0] ccl;
   logic [RW-1:0]  rcl;
   logic [IW-1:0]  cell_addr;
   logic [IW-1:0]  lin_addr;
   logic [31:0]    lin32;
   logic           copy_last, fill_last;
   logic           we, re;
   logic [IW-1:0]  waddr, raddr;
   logic [15:0]    wdata;
   logic [7:0]     blank_attr;

   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

   assign colx = {2'b00, col_ff};
   assign rowx = {3'b000, row_ff};
   assign ccl = (colx > 9'(COLUMNS - 1)) ? CLW'(COLUMNS - 1) : colx[CLW-1:0];
   assign rcl = (rowx > 8'(ROWS - 1)) ? RW'(ROWS - 1) : rowx[RW-1:0];
   assign cell_addr = IW'(IW'(rcl) * IW'(COLUMNS)) + IW'(ccl);
   assign lin_addr = lin_ff[IW-1:0];
   assign lin32 = 32'(lin_ff);

   assign copy_last = (sweep_ff == IW'(CELLS - COLUMNS));
   assign fill_last = (sweep_ff == IW'(CELLS - 1));
   assign blank_attr = dp_cmd.fill_init ? FILL_ATTR_RESET : fill_attr_ff;

   always_comb begin
      dp_status.command = cmd_ff;
      dp_status.char_code = ch_ff;
      dp_status.at_end = (crow_ff == RW'(ROWS));
      dp_status.last_row = (crow_ff == RW'(ROWS - 1));
      dp_status.cur_zero = (lin_ff == '0);
      dp_status.copy_last = copy_last;
      dp_status.fill_last = fill_last;
      dp_status.tab_zero = (tab_ff == '0);
      dp_status.rsp_free = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      we = 1'b0;
      re = 1'b0;
      waddr = lin_addr;
      raddr = lin_addr;
      wdata = {char_attr_ff, ch_ff};
      case (dp_cmd.op)
         OP_RDCELL: begin
            re = 1'b1;
            raddr = cell_addr;
         end
         OP_BS_RD: begin
            re = 1'b1;
         end
         OP_BS_WR: begin
            we = 1'b1;
            wdata = {rdata_ff[15:8], CH_BLANK};
         end
         OP_PUT: begin
            we = 1'b1;
            wdata = {char_attr_ff, dp_cmd.put_blank ? CH_BLANK : ch_ff};
         end
         OP_FILL: begin
            we = 1'b1;
            waddr = sweep_ff;
            wdata = {blank_attr, CH_BLANK};
         end
         OP_COPY: begin
            re = !copy_last;
            raddr = sweep_ff + IW'(COLUMNS);
            we = (sweep_ff != '0);
            waddr = sweep_ff - IW'(1);
            wdata = rdata_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      lin_in = lin_ff;
      crow_in = crow_ff;
      ccol_in = ccol_ff;
      sweep_in = sweep_ff;
      tab_in = tab_ff;
      case (dp_cmd.op)
         OP_SETCUR: begin
            crow_in = rcl;
            ccol_in = ccl;
            lin_in = CW'(cell_addr);
         end
         OP_SWEEP_CLR: begin
            sweep_in = '0;
         end
         OP_CLEAR_START: begin
            sweep_in = '0;
            lin_in = '0;
            crow_in = '0;
            ccol_in = '0;
         end
         OP_COPY: begin
            if (!copy_last) begin
               sweep_in = sweep_ff + IW'(1);
            end
         end
         OP_FILL: begin
            if (!fill_last) begin
               sweep_in = sweep_ff + IW'(1);
            end
         end
         OP_LASTROW: begin
            lin_in = CW'(CELLS - COLUMNS);
            crow_in = RW'(ROWS - 1);
            ccol_in = '0;
         end
         OP_NEWLINE: begin
            lin_in = lin_ff - CW'(ccol_ff) + CW'(COLUMNS);
            crow_in = crow_ff + RW'(1);
            ccol_in = '0;
         end
         OP_PUT: begin
            lin_in = lin_ff + CW'(1);
            if (ccol_ff == CLW'(COLUMNS - 1)) begin
               ccol_in = '0;
               crow_in = crow_ff + RW'(1);
            end else begin
               ccol_in = ccol_ff + CLW'(1);
            end
            if (dp_cmd.put_blank) begin
               tab_in = tab_ff - 4'd1;
            end
         end
         OP_BS_DEC: begin
            lin_in = lin_ff - CW'(1);
            if (ccol_ff == '0) begin
               ccol_in = CLW'(COLUMNS - 1);
               crow_in = crow_ff - RW'(1);
            end else begin
               ccol_in = ccol_ff - CLW'(1);
            end
         end
         OP_TAB_LOAD: begin
            tab_in = tab_width_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         cells_mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= cells_mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.op == OP_LATCH) begin
         cmd_ff <= req_tdata[1:0];
         ch_ff <= req_tdata[9:2];
         col_ff <= req_tdata[16:10];
         row_ff <= req_tdata[21:17];
      end
      if (dp_cmd.op == OP_RSP) begin
         rsp_data_ff <= {5'b00000,
                         (cmd_ff == CMD_READ) ? rdata_ff : 16'h0000,
                         lin32[10:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lin_ff <= '0;
         crow_ff <= '0;
         ccol_ff <= '0;
         sweep_ff <= '0;
         tab_ff <= '0;
         char_attr_ff <= CHAR_ATTR_RESET;
         fill_attr_ff <= FILL_ATTR_RESET;
         tab_width_ff <= TAB_WIDTH_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         lin_ff <= lin_in;
         crow_ff <= crow_in;
         ccol_ff <= ccol_in;
         sweep_ff <= sweep_in;
         tab_ff <= tab_in;
         if (csr_valid) begin
            case (csr_index)
               REG_CHAR_ATTR: char_attr_ff <= csr_data;
               REG_FILL_ATTR: fill_attr_ff <= csr_data;
               REG_TAB_WIDTH: tab_width_ff <= csr_data[3:0];
               default: begin
               end
            endcase
         end
         if (dp_cmd.op == OP_RSP) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

// ----- design/text_console_writer_top.sv -----
// Text-mode screen engine with a COLUMNS x ROWS store of character and
// attribute cells and a linear cursor. Commands arrive as items on the req_
// stream channel and each one returns exactly one item on the rsp_ channel
// carrying the cursor position and, for a read, the addressed cell.
// Attribute and tab settings are written through the csr_ channel while the
// block is idle; the user is bound to that, as the block itself does not
// enforce it. csr_ready is always high. A backspace reads the cell before
// the cursor and then writes a blank to it with that cell's attribute kept,
// and a tab writes as many blank cells as the tab width. A scroll walks the
// whole store through the cell memory's read and write ports, and a clear
// blanks every cell. One item is worked on at a time, and req_tready
// returns in the cycle its result becomes valid.
// After reset the engine blanks every cell, one cell per cycle; req_tready
// stays low during that pass.
// The result sits in an output register; if the receiver stalls, the next
// item is still accepted and worked, and its result waits for the slot.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer_top #(
   parameter int COLUMNS = 80,
   parameter int ROWS = 25
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // command[1:0], char_code[9:2], column[16:10], line[21:17], zero[23:22]
   input  wire [23:0]  req_tdata,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // cursor_pos[10:0], read_char[18:11], read_attr[26:19], zero[31:27]
   output logic [31:0] rsp_tdata,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire [1:0]   csr_index,
   input  wire [7:0]   csr_data
);
   import tcw_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   tcw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .dp_cmd     (dp_cmd),
      .dp_status  (dp_status)
   );

   tcw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .dp_cmd     (dp_cmd),
      .dp_status  (dp_status)
   );

endmodule

`default_nettype wire
